### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

    localparam int unsigned CP_W   = 31;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned MODE_W = 2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

    localparam logic [MODE_W-1:0] MODE_LATIN1 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UCS2   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL   = 2'd2;

    localparam logic [BYTE_W-1:0] LEAD_MIN    = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_3      = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4      = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5      = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6      = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD_BAD    = 8'hFE;
    localparam logic [BYTE_W-1:0] CONT_MIN_3  = 8'hA0;
    localparam logic [BYTE_W-1:0] CONT_MIN_4  = 8'h90;
    localparam logic [BYTE_W-1:0] CONT_MIN_5  = 8'h88;
    localparam logic [BYTE_W-1:0] CONT_MIN_6  = 8'h84;

    typedef struct packed {
        logic                   emit;
        logic [CP_W-1:0]        code_point;
        status_t                status;
        logic [LEN_W-1:0]       seq_length;
    } result_t;

    function automatic status_t range_status(input logic [MODE_W-1:0] mode,
                                             input logic [CP_W-1:0] cp);
        status_t st;
        st = STATUS_OK;
        if (mode == MODE_LATIN1)
        begin
            if (cp[CP_W-1:8] != '0)
                st = STATUS_RANGE;
        end
        else if (mode == MODE_UCS2)
        begin
            if (cp[CP_W-1:16] != '0 || cp[15:11] == 5'b11011)
                st = STATUS_RANGE;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

### rtl/u8d_if.sv
// Valid/ready channel interfaces for bytes, results and configuration.
`default_nettype none

interface u8d_byte_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_result_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::CP_W-1:0]   code_point;
    u8d_pkg::status_t           status;
    logic [u8d_pkg::LEN_W-1:0]  seq_length;

    modport source (output valid, output code_point, output status, output seq_length,
                    input ready);
    modport sink   (input valid, input code_point, input status, input seq_length,
                    output ready);
endinterface

interface u8d_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::MODE_W-1:0] output_mode;

    modport source (output valid, output output_mode, input ready);
    modport sink   (input valid, input output_mode, output ready);
endinterface

`default_nettype wire

### rtl/u8d_in_stage.sv
// Input register stage holding one accepted byte.
`default_nettype none

module u8d_in_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    u8d_byte_if.sink                        byte_ch,
    input  wire logic                       advance,
    output logic                            valid,
    output logic [u8d_pkg::BYTE_W-1:0]      data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [u8d_pkg::BYTE_W-1:0] data_reg;
    logic                       take;

    assign byte_ch.ready = !valid_reg || advance;
    assign take          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= byte_ch.byte_in;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

### rtl/u8d_decode.sv
// Sequence state and per-byte decode logic.
`default_nettype none

module u8d_decode (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [u8d_pkg::BYTE_W-1:0] data,
    input  wire logic [u8d_pkg::MODE_W-1:0] mode,
    output u8d_pkg::result_t                result
);

    logic [u8d_pkg::LEN_W-1:0]  pending_reg,  pending_next;
    logic [u8d_pkg::LEN_W-1:0]  total_reg,    total_next;
    logic [u8d_pkg::CP_W-1:0]   acc_reg,      acc_next;
    logic [u8d_pkg::BYTE_W-1:0] lead_reg,     lead_next;
    logic                       bad_reg,      bad_next;
    logic                       first_cont;
    logic                       overlong;
    logic                       bad_acc;
    logic [u8d_pkg::CP_W-1:0]   acc_shift;
    logic [u8d_pkg::LEN_W-1:0]  pending_dec;

    assign first_cont  = ({1'b0, pending_reg} + 4'd1) == {1'b0, total_reg};
    assign overlong    = (lead_reg == u8d_pkg::LEAD_3 && data < u8d_pkg::CONT_MIN_3)
                      || (lead_reg == u8d_pkg::LEAD_4 && data < u8d_pkg::CONT_MIN_4)
                      || (lead_reg == u8d_pkg::LEAD_5 && data < u8d_pkg::CONT_MIN_5)
                      || (lead_reg == u8d_pkg::LEAD_6 && data < u8d_pkg::CONT_MIN_6);
    assign bad_acc     = bad_reg || (data[7:6] != 2'b10) || (first_cont && overlong);
    assign acc_shift   = {acc_reg[u8d_pkg::CP_W-7:0], data[5:0]};
    assign pending_dec = pending_reg - 3'd1;

    always_comb
    begin
        pending_next      = pending_reg;
        total_next        = total_reg;
        acc_next          = acc_reg;
        lead_next         = lead_reg;
        bad_next          = bad_reg;
        result.emit       = 1'b0;
        result.code_point = '0;
        result.status     = u8d_pkg::STATUS_OK;
        result.seq_length = 3'd1;
        if (pending_reg == '0)
        begin
            priority if (!data[7])
            begin
                result.emit       = 1'b1;
                result.status     = u8d_pkg::range_status(mode, {23'd0, data});
                result.code_point = (result.status == u8d_pkg::STATUS_OK)
                                    ? {23'd0, data} : '0;
            end
            else if (data < u8d_pkg::LEAD_MIN || data >= u8d_pkg::LEAD_BAD)
            begin
                result.emit   = 1'b1;
                result.status = u8d_pkg::STATUS_MALFORMED;
            end
            else
            begin
                lead_next = data;
                bad_next  = 1'b0;
                priority if (data < u8d_pkg::LEAD_3)
                begin
                    total_next = 3'd2;
                    acc_next   = {26'd0, data[4:0]};
                end
                else if (data < u8d_pkg::LEAD_4)
                begin
                    total_next = 3'd3;
                    acc_next   = {27'd0, data[3:0]};
                end
                else if (data < u8d_pkg::LEAD_5)
                begin
                    total_next = 3'd4;
                    acc_next   = {28'd0, data[2:0]};
                end
                else if (data < u8d_pkg::LEAD_6)
                begin
                    total_next = 3'd5;
                    acc_next   = {29'd0, data[1:0]};
                end
                else
                begin
                    total_next = 3'd6;
                    acc_next   = {30'd0, data[0]};
                end
                pending_next = total_next - 3'd1;
            end
        end
        else
        begin
            pending_next = pending_dec;
            acc_next     = acc_shift;
            bad_next     = bad_acc;
            if (pending_dec == '0)
            begin
                result.emit       = 1'b1;
                result.seq_length = total_reg;
                result.status     = bad_acc ? u8d_pkg::STATUS_MALFORMED
                                            : u8d_pkg::range_status(mode, acc_shift);
                result.code_point = (result.status == u8d_pkg::STATUS_OK) ? acc_shift : '0;
                total_next        = '0;
                acc_next          = '0;
                lead_next         = '0;
                bad_next          = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            total_reg   <= '0;
            acc_reg     <= '0;
            lead_reg    <= '0;
            bad_reg     <= 1'b0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            total_reg   <= total_next;
            acc_reg     <= acc_next;
            lead_reg    <= lead_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

`default_nettype wire

### rtl/u8d_out_stage.sv
// Result register driving the output channel.
`default_nettype none

module u8d_out_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire u8d_pkg::result_t           result,
    u8d_result_if.source                    res_ch,
    output logic                            slot_free
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [u8d_pkg::CP_W-1:0]   cp_reg;
    u8d_pkg::status_t           status_reg;
    logic [u8d_pkg::LEN_W-1:0]  len_reg;
    logic                       load;

    assign slot_free = !valid_reg || res_ch.ready;
    assign load      = advance && result.emit;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg     <= result.code_point;
            status_reg <= result.status;
            len_reg    <= result.seq_length;
        end
    end

    assign res_ch.valid      = valid_reg;
    assign res_ch.code_point = cp_reg;
    assign res_ch.status     = status_reg;
    assign res_ch.seq_length = len_reg;

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder.sv
// Top level: UTF-8 stream decoder with legacy 5- and 6-byte forms.
// A result's last byte is held in the input register, then the result is registered in the output stage.
// Throughput: one byte per cycle, limited by the input and result registers.
// Reset: asynchronous, clears sequence state and both stages; output_mode returns to 2.
// A stalled result register holds the input stage; a free one passes one byte a cycle.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8d_byte_if.sink    byte_ch,
    u8d_cfg_if.sink     cfg,
    u8d_result_if.source res_ch
);

    logic [u8d_pkg::MODE_W-1:0] mode_reg;
    logic                       in_valid;
    logic [u8d_pkg::BYTE_W-1:0] in_data;
    logic                       slot_free;
    logic                       advance;
    u8d_pkg::result_t           result;

    assign cfg.ready = 1'b1;
    assign advance   = in_valid && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= u8d_pkg::MODE_FULL;
        else if (cfg.valid)
            mode_reg <= cfg.output_mode;
    end

    u8d_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .advance (advance),
        .valid   (in_valid),
        .data    (in_data)
    );

    u8d_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .data    (in_data),
        .mode    (mode_reg),
        .result  (result)
    );

    u8d_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .res_ch    (res_ch),
        .slot_free (slot_free)
    );

    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.status != u8d_pkg::STATUS_OK |-> res_ch.code_point == '0)
        else $error("non-ok result carries a code point");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> res_ch.seq_length != 3'd0 && res_ch.seq_length != 3'd7)
        else $error("sequence length out of range");

    a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.status == u8d_pkg::STATUS_OK && res_ch.seq_length == 3'd1
        |-> res_ch.code_point[u8d_pkg::CP_W-1:7] == '0)
        else $error("one-byte result above 0x7F");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !slot_free |=> in_valid && $stable(in_data))
        else $error("input stage lost a byte while stalled");

endmodule

`default_nettype wire
